// ===== rtl/owc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owc_pkg
// Shared types, constants and the CORDIC arctangent table for the odometry
// corner warp block.
// ----------------------------------------------------------------------------
package owc_pkg;

    localparam int CS_W         = 34;        // CORDIC x/y/z width, Q2.30 plus guard
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = 5;
    localparam int TS_W         = 29;        // turn scale as a signed operand
    localparam int TURN_SCALE   = 174992711;
    localparam int X_DIV        = 8100;
    localparam int Y_DIV        = 10800;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic signed [CS_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [3:0]  DEBOUNCE_RESET = 4'd3;
    localparam logic [15:0] LAG_RESET      = 16'd62259;

    typedef enum logic [1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_LAG      = 2'd1,
        CFG_UMARGIN  = 2'd2,
        CFG_VMARGIN  = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_ROT,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        OP_LAG,
        OP_PHB,
        OP_PHA,
        OP_WX,
        OP_WY,
        OP_RX,
        OP_RY
    } mac_op_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [29:0] atan_turn(input logic [STEP_W-1:0] i);
        logic [29:0] r;
        begin
            case (i)
                5'd0:    r = 30'd536870912;
                5'd1:    r = 30'd316933406;
                5'd2:    r = 30'd167458907;
                5'd3:    r = 30'd85004756;
                5'd4:    r = 30'd42667331;
                5'd5:    r = 30'd21354465;
                5'd6:    r = 30'd10679838;
                5'd7:    r = 30'd5340245;
                5'd8:    r = 30'd2670163;
                5'd9:    r = 30'd1335087;
                5'd10:   r = 30'd667544;
                5'd11:   r = 30'd333772;
                5'd12:   r = 30'd166886;
                5'd13:   r = 30'd83443;
                5'd14:   r = 30'd41722;
                5'd15:   r = 30'd20861;
                5'd16:   r = 30'd10430;
                5'd17:   r = 30'd5215;
                5'd18:   r = 30'd2608;
                5'd19:   r = 30'd1304;
                5'd20:   r = 30'd652;
                5'd21:   r = 30'd326;
                5'd22:   r = 30'd163;
                5'd23:   r = 30'd81;
                default: r = 30'd0;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/owc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owc_if
// Valid/ready channels: odometry sample in, mapped corner out.
// ----------------------------------------------------------------------------
interface owc_in_if #(
    parameter int POS_W = 24,
    parameter int ANG_W = 16
);
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  enc_x;
    logic signed [POS_W-1:0]  enc_y;
    logic signed [ANG_W-1:0]  enc_theta;
    logic                     reset_flag;

    modport source (output valid, enc_x, enc_y, enc_theta, reset_flag, input ready);
    modport sink   (input valid, enc_x, enc_y, enc_theta, reset_flag, output ready);
endinterface

interface owc_out_if #(
    parameter int COORD_W = 21
);
    logic                      valid;
    logic                      ready;
    logic [1:0]                corner_index;
    logic signed [COORD_W-1:0] u_coord;
    logic signed [COORD_W-1:0] v_coord;
    logic                      saturated;
    logic                      last;

    modport source (output valid, corner_index, u_coord, v_coord, saturated, last,
                    input ready);
    modport sink   (input valid, corner_index, u_coord, v_coord, saturated, last,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/owc_cdiv.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owc_cdiv
// Divide of (diff << FRAC_BITS) by a constant, truncated toward zero.
// Reciprocal multiply, then one remainder check; done is registered together with the corrected quotient.
// ----------------------------------------------------------------------------
module owc_cdiv #(
    parameter int DIVISOR   = 8100,
    parameter int DIFF_W    = 25,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic signed [DIFF_W-1:0]       diff,
    output logic                                done,
    output logic signed [DIFF_W+FRAC_BITS:0]    quot
);
    localparam int N     = DIFF_W + FRAC_BITS;
    localparam int RCP_W = N - $clog2(DIVISOR) + 1;
    // floor(2^N / DIVISOR); with |diff| < 2^DIFF_W the estimate is low by at most one
    localparam logic [RCP_W-1:0] RCP   = RCP_W'((64'd1 << N) / 64'(DIVISOR));
    localparam logic [N-1:0]     DIV_N = N'(DIVISOR);

    logic [DIFF_W-1:0]       mag_reg;
    logic [DIFF_W+RCP_W-1:0] prod_reg;
    logic [RCP_W-1:0]        q0_reg;
    logic [N-1:0]            rem_reg, quo_reg;
    logic                    neg_reg;
    logic [3:0]              stage_reg;
    logic                    done_reg;

    logic [DIFF_W-1:0] mag;

    assign mag = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= {stage_reg[2:0], start};
            if (start)
            begin
                done_reg <= 1'b0;
            end
            else if (stage_reg[3])
            begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= mag;
            neg_reg <= diff[DIFF_W-1];
        end
        if (stage_reg[0])
        begin
            prod_reg <= mag_reg * RCP;
        end
        if (stage_reg[1])
        begin
            q0_reg <= prod_reg[DIFF_W+RCP_W-1:DIFF_W];
        end
        if (stage_reg[2])
        begin
            rem_reg <= {mag_reg, {FRAC_BITS{1'b0}}} - N'(q0_reg) * DIV_N;
        end
        if (stage_reg[3])
        begin
            quo_reg <= N'(q0_reg) + N'(rem_reg >= DIV_N);
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

endmodule
`default_nettype wire

// ===== rtl/owc_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owc_cordic
// Iterative rotation-mode CORDIC: phase in 2^-32 turn to cos/sin in Q2.30.
// Quadrant fold first, then one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module owc_cordic
    import owc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [31:0]            phase,
    output logic                        done,
    output logic signed [CS_W-1:0]      cos_out,
    output logic signed [CS_W-1:0]      sin_out
);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    logic signed [CS_W-1:0] x_reg, y_reg, z_reg;
    logic [1:0]             q_reg;
    logic [STEP_W-1:0]      step_reg;
    logic                   busy_reg, done_reg;

    logic [31:0]            qsum, dres;
    logic [1:0]             q_in;
    logic signed [CS_W-1:0] xs, ys, at;

    assign qsum = phase + 32'h2000_0000;
    assign q_in = qsum[31:30];
    assign dres = phase - {q_in, 30'd0};
    assign xs   = x_reg >>> step_reg;
    assign ys   = y_reg >>> step_reg;
    assign at   = $signed({{(CS_W-30){1'b0}}, atan_turn(step_reg)});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= CORDIC_GAIN;
            y_reg <= '0;
            z_reg <= CS_W'($signed(dres));
            q_reg <= q_in;
        end
        else if (busy_reg)
        begin
            if (!z_reg[CS_W-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
    end

    always_comb
    begin
        case (q_reg)
            2'd0:
            begin
                cos_out = x_reg;
                sin_out = y_reg;
            end
            2'd1:
            begin
                cos_out = -y_reg;
                sin_out = x_reg;
            end
            2'd2:
            begin
                cos_out = -x_reg;
                sin_out = -y_reg;
            end
            default:
            begin
                cos_out = y_reg;
                sin_out = -x_reg;
            end
        endcase
    end

    assign done = done_reg;

endmodule
`default_nettype wire

// ===== rtl/odometry_corner_warp_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// odometry_corner_warp_core
// Relative SE(2) pose warp of four margin corners per odometry sample,
// built around one shared multiply-accumulate unit and one CORDIC.
// ----------------------------------------------------------------------------
//  channel  | dir | beat
//  ---------+-----+-------------------------------------------------------
//  in_ch    | in  | enc_x, enc_y, enc_theta, reset_flag (one sample)
//  out_ch   | out | corner_index, u_coord, v_coord, saturated, last (x4)
//  cfg_*    | in  | write enable, register index, 16-bit data
//
//  Per sample: MAC passes for the lag and the two phase products, then two
//  24-step CORDIC runs (the constant divides finish inside them), then the
//  WX, WY, RX and RY MAC passes and one output beat per corner, plus the
//  idle state that takes the next sample.
//  in_ch.ready is high only while idle; each corner beat holds until taken.
//  Reset clears the pose history and loads register defaults.
// ----------------------------------------------------------------------------
module odometry_corner_warp_core
    import owc_pkg::*;
#(
    parameter int POSITION_WIDTH  = 24,
    parameter int ANGLE_WIDTH     = 16,
    parameter int COORD_FRAC_BITS = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    owc_in_if.sink                      in_ch,
    owc_out_if.source                   out_ch
);
    localparam int P       = POSITION_WIDTH;
    localparam int A       = ANGLE_WIDTH;
    localparam int F       = COORD_FRAC_BITS;
    localparam int COORD_W = F + 5;
    localparam int DIFF_W  = P + 1;
    localparam int DQ_W    = DIFF_W + F + 1;
    localparam int MB_W    = (F + 8 > TS_W) ? F + 8 : TS_W;
    localparam int PW      = CS_W + MB_W;
    localparam int ACC_W   = PW + 1;
    localparam int SH_W    = ACC_W - 30;
    localparam int E_W     = F + 8;
    localparam int SUM_W   = ((DQ_W > SH_W) ? DQ_W : SH_W) + 1;

    localparam logic signed [SUM_W-1:0] EMAX = {{(SUM_W-F-7){1'b0}}, {(F+7){1'b1}}};
    localparam logic signed [SUM_W-1:0] EMIN = -EMAX;
    localparam logic signed [SH_W-1:0]  OMAX = {{(SH_W-F-4){1'b0}}, {(F+4){1'b1}}};
    localparam logic signed [SH_W-1:0]  OMIN = {{(SH_W-F-4){1'b1}}, {(F+4){1'b0}}};
    localparam logic signed [P-1:0]     PMIN = {1'b1, {(P-1){1'b0}}};
    localparam logic signed [P-1:0]     PMAX = {1'b0, {(P-1){1'b1}}};
    localparam logic signed [MB_W-1:0]  TS_B = MB_W'(TURN_SCALE);

    // configuration
    logic [3:0]  debounce_reg;
    logic [15:0] lag_f_reg, u_margin_reg, v_margin_reg;

    // pose history
    logic signed [A-1:0] held_reg, prev_heading_reg;
    logic [3:0]          mismatch_reg;
    logic signed [P-1:0] prev_x_reg, prev_y_reg;
    logic                prev_level_reg;

    // per-sample working registers
    logic signed [P-1:0]      xb_reg, yb_reg;
    logic                     toggle_reg, level_reg;
    logic signed [A-1:0]      lag_reg;
    logic [31:0]              phase_a_reg, phase_b_reg;
    logic signed [CS_W-1:0]   cb_reg, sb_reg, ca_reg, sa_reg;
    logic signed [E_W-1:0]    ex_reg, ey_reg;
    logic signed [COORD_W-1:0] u_reg, v_reg;
    logic                     sat_u_reg, sat_reg;

    // sequencer
    state_t       state_reg, state_next;
    mac_op_t      op_reg, op_next;
    logic [1:0]   ph_reg, ph_next;
    logic [1:0]   corner_reg, corner_next;
    logic         rot_a_reg, rot_a_next;

    // MAC unit
    logic signed [CS_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic                   mul_sub;
    logic signed [PW-1:0]   prod_reg;
    logic signed [ACC_W-1:0] acc_reg;

    // sub-units
    logic                   cor_start, cor_done, div_start, dx_done, dy_done;
    logic [31:0]            cor_phase;
    logic signed [CS_W-1:0] cor_cos, cor_sin;
    logic signed [DQ_W-1:0] dx, dy;
    logic signed [DIFF_W-1:0] diff_x, diff_y;

    logic in_beat, out_beat, capture, sample_done;

    assign in_beat     = in_ch.valid && in_ch.ready;
    assign out_beat    = out_ch.valid && out_ch.ready;
    assign capture     = (state_reg == ST_MAC) && (ph_reg == 2'd3);
    assign sample_done = out_beat && (corner_reg == 2'd3);

    // ------------------------------------------------------------------
    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            lag_f_reg    <= LAG_RESET;
            u_margin_reg <= '0;
            v_margin_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_DEBOUNCE: debounce_reg <= cfg_data[3:0];
                CFG_LAG:      lag_f_reg    <= cfg_data;
                CFG_UMARGIN:  u_margin_reg <= cfg_data;
                CFG_VMARGIN:  v_margin_reg <= cfg_data;
                default:      debounce_reg <= debounce_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // heading glitch filter and position quarter turn at accept
    logic [3:0]          mm_inc;
    logic signed [P-1:0] xb_in;

    assign mm_inc = mismatch_reg + 1'b1;
    assign xb_in  = (in_ch.enc_y == PMIN) ? PMAX : -in_ch.enc_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg         <= '0;
            mismatch_reg     <= '0;
            prev_heading_reg <= '0;
            prev_x_reg       <= '0;
            prev_y_reg       <= '0;
            prev_level_reg   <= 1'b0;
        end
        else
        begin
            if (in_beat)
            begin
                if (in_ch.enc_theta != held_reg)
                begin
                    if (mm_inc >= debounce_reg)
                    begin
                        mismatch_reg <= '0;
                        held_reg     <= in_ch.enc_theta;
                    end
                    else
                    begin
                        mismatch_reg <= mm_inc;
                    end
                end
                else
                begin
                    mismatch_reg <= '0;
                end
            end
            // level change wipes history once the lag has used it
            if (capture && (op_reg == OP_LAG) && toggle_reg)
            begin
                prev_heading_reg <= '0;
                prev_x_reg       <= '0;
                prev_y_reg       <= '0;
            end
            if (sample_done)
            begin
                prev_heading_reg <= lag_reg;
                prev_x_reg       <= xb_reg;
                prev_y_reg       <= yb_reg;
                prev_level_reg   <= level_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            xb_reg     <= xb_in;
            yb_reg     <= in_ch.enc_x;
            toggle_reg <= in_ch.reset_flag != prev_level_reg;
            level_reg  <= in_ch.reset_flag;
        end
    end

    // ------------------------------------------------------------------
    // next state
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        ph_next     = ph_reg;
        corner_next = corner_reg;
        rot_a_next  = rot_a_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = ST_MAC;
                    op_next    = OP_LAG;
                    ph_next    = 2'd0;
                end
            end
            ST_MAC:
            begin
                ph_next = ph_reg + 1'b1;
                if (ph_reg == 2'd3)
                begin
                    case (op_reg)
                        OP_LAG: op_next = OP_PHB;
                        OP_PHB: op_next = OP_PHA;
                        OP_PHA:
                        begin
                            state_next = ST_ROT;
                            rot_a_next = 1'b0;
                        end
                        OP_WX:  op_next = OP_WY;
                        OP_WY:  op_next = OP_RX;
                        OP_RX:  op_next = OP_RY;
                        default: state_next = ST_EMIT;
                    endcase
                end
            end
            ST_ROT:
            begin
                if (cor_done && !rot_a_reg)
                begin
                    rot_a_next = 1'b1;
                end
                else if (cor_done && rot_a_reg && dx_done && dy_done)
                begin
                    state_next  = ST_MAC;
                    op_next     = OP_WX;
                    ph_next     = 2'd0;
                    corner_next = 2'd0;
                end
            end
            ST_EMIT:
            begin
                if (out_beat)
                begin
                    if (corner_reg == 2'd3)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next  = ST_MAC;
                        op_next     = OP_WX;
                        ph_next     = 2'd0;
                        corner_next = corner_reg + 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            op_reg     <= OP_LAG;
            ph_reg     <= '0;
            corner_reg <= '0;
            rot_a_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            ph_reg     <= ph_next;
            corner_reg <= corner_next;
            rot_a_reg  <= rot_a_next;
        end
    end

    // ------------------------------------------------------------------
    // operand selection and unit starts
    function automatic logic signed [MB_W-1:0] to_q(input logic [16:0] v);
        logic [16+F:0] w;
        begin
            w = {v, {F{1'b0}}};
            return $signed({{(MB_W-F-1){1'b0}}, w[16+F:16]});
        end
    endfunction

    logic [16:0]            lag_w, u_val, v_val;
    logic signed [MB_W-1:0] px, py, f_b, fw_b, ex_b, ey_b;
    logic signed [CS_W-1:0] prev_a, held_a, lag_a;

    assign lag_w  = 17'h10000 - {1'b0, lag_f_reg};
    assign u_val  = corner_reg[1] ? (17'h10000 - {1'b0, u_margin_reg}) : {1'b0, u_margin_reg};
    assign v_val  = corner_reg[0] ? (17'h10000 - {1'b0, v_margin_reg}) : {1'b0, v_margin_reg};
    assign px     = to_q(u_val);
    assign py     = to_q(v_val);
    assign f_b    = $signed({{(MB_W-16){1'b0}}, lag_f_reg});
    assign fw_b   = $signed({{(MB_W-17){1'b0}}, lag_w});
    assign ex_b   = MB_W'(ex_reg);
    assign ey_b   = MB_W'(ey_reg);
    assign prev_a = CS_W'(prev_heading_reg);
    assign held_a = CS_W'(held_reg);
    assign lag_a  = CS_W'(lag_reg);

    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mul_sub = 1'b0;
        case (op_reg)
            OP_LAG:
            begin
                mul_a = (ph_reg == 2'd0) ? prev_a : held_a;
                mul_b = (ph_reg == 2'd0) ? f_b : fw_b;
            end
            OP_PHB:
            begin
                mul_a = (ph_reg == 2'd0) ? lag_a : '0;
                mul_b = TS_B;
            end
            OP_PHA:
            begin
                mul_a = (ph_reg == 2'd0) ? prev_a : '0;
                mul_b = TS_B;
            end
            OP_WX:
            begin
                mul_a   = (ph_reg == 2'd0) ? cb_reg : sb_reg;
                mul_b   = (ph_reg == 2'd0) ? px : py;
                mul_sub = 1'b1;
            end
            OP_WY:
            begin
                mul_a = (ph_reg == 2'd0) ? sb_reg : cb_reg;
                mul_b = (ph_reg == 2'd0) ? px : py;
            end
            OP_RX:
            begin
                mul_a = (ph_reg == 2'd0) ? ca_reg : sa_reg;
                mul_b = (ph_reg == 2'd0) ? ex_b : ey_b;
            end
            OP_RY:
            begin
                mul_a   = (ph_reg == 2'd0) ? ca_reg : sa_reg;
                mul_b   = (ph_reg == 2'd0) ? ey_b : ex_b;
                mul_sub = 1'b1;
            end
            default: mul_sub = 1'b0;
        endcase
    end

    assign cor_start = (capture && (op_reg == OP_PHA))
                    || ((state_reg == ST_ROT) && !rot_a_reg && cor_done);
    assign cor_phase = (state_reg == ST_ROT) ? phase_a_reg : phase_b_reg;
    assign div_start = capture && (op_reg == OP_PHA);
    assign diff_x    = DIFF_W'(xb_reg) - DIFF_W'(prev_x_reg);
    assign diff_y    = DIFF_W'(yb_reg) - DIFF_W'(prev_y_reg);

    // ------------------------------------------------------------------
    // MAC: product register, then accumulate (ph1 load, ph2 add/sub)
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (state_reg == ST_MAC)
        begin
            if (ph_reg == 2'd1)
            begin
                acc_reg <= ACC_W'(prod_reg);
            end
            else if (ph_reg == 2'd2)
            begin
                acc_reg <= mul_sub ? (acc_reg - ACC_W'(prod_reg))
                                   : (acc_reg + ACC_W'(prod_reg));
            end
        end
    end

    // ------------------------------------------------------------------
    // result capture
    logic signed [ACC_W-17:0] lag_q;
    logic signed [SH_W-1:0]   sh;
    logic signed [SUM_W-1:0]  e_sum;
    logic signed [E_W-1:0]    e_clamp;
    logic signed [COORD_W-1:0] o_clamp;
    logic                     o_sat;

    assign lag_q = $signed(acc_reg[ACC_W-1:16])
                 + $signed({{(ACC_W-17){1'b0}}, acc_reg[ACC_W-1] && (acc_reg[15:0] != '0)});
    assign sh    = acc_reg[ACC_W-1:30];
    assign e_sum = SUM_W'(sh) + ((op_reg == OP_WX) ? SUM_W'(dx) : SUM_W'(dy));

    always_comb
    begin
        if (e_sum > EMAX)
        begin
            e_clamp = EMAX[E_W-1:0];
        end
        else if (e_sum < EMIN)
        begin
            e_clamp = EMIN[E_W-1:0];
        end
        else
        begin
            e_clamp = e_sum[E_W-1:0];
        end
        o_sat = 1'b1;
        if (sh > OMAX)
        begin
            o_clamp = OMAX[COORD_W-1:0];
        end
        else if (sh < OMIN)
        begin
            o_clamp = OMIN[COORD_W-1:0];
        end
        else
        begin
            o_clamp = sh[COORD_W-1:0];
            o_sat   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            case (op_reg)
                OP_LAG: lag_reg     <= lag_q[A-1:0];
                OP_PHB: phase_b_reg <= acc_reg[39:8];
                OP_PHA: phase_a_reg <= acc_reg[39:8];
                OP_WX:  ex_reg      <= e_clamp;
                OP_WY:  ey_reg      <= e_clamp;
                OP_RX:
                begin
                    u_reg     <= o_clamp;
                    sat_u_reg <= o_sat;
                end
                OP_RY:
                begin
                    v_reg   <= o_clamp;
                    sat_reg <= sat_u_reg || o_sat;
                end
                default: lag_reg <= lag_reg;
            endcase
        end
        if ((state_reg == ST_ROT) && cor_done)
        begin
            if (!rot_a_reg)
            begin
                cb_reg <= cor_cos;
                sb_reg <= cor_sin;
            end
            else
            begin
                ca_reg <= cor_cos;
                sa_reg <= cor_sin;
            end
        end
    end

    // ------------------------------------------------------------------
    // shared CORDIC and the two constant dividers
    owc_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .phase   (cor_phase),
        .done    (cor_done),
        .cos_out (cor_cos),
        .sin_out (cor_sin)
    );

    owc_cdiv #(
        .DIVISOR   (X_DIV),
        .DIFF_W    (DIFF_W),
        .FRAC_BITS (F)
    ) u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .diff  (diff_x),
        .done  (dx_done),
        .quot  (dx)
    );

    owc_cdiv #(
        .DIVISOR   (Y_DIV),
        .DIFF_W    (DIFF_W),
        .FRAC_BITS (F)
    ) u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .diff  (diff_y),
        .done  (dy_done),
        .quot  (dy)
    );

    // ------------------------------------------------------------------
    // channel outputs
    assign in_ch.ready         = (state_reg == ST_IDLE);
    assign out_ch.valid        = (state_reg == ST_EMIT);
    assign out_ch.corner_index = corner_reg;
    assign out_ch.u_coord      = u_reg;
    assign out_ch.v_coord      = v_reg;
    assign out_ch.saturated    = sat_reg;
    assign out_ch.last         = (corner_reg == 2'd3);

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid))
        else $error("input taken while a corner beat is pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready && !out_ch.valid)
        else $error("sequencer did not leave idle after a sample");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.ready && out_ch.last |=> in_ch.ready)
        else $error("not idle after the fourth corner");

    a_corner_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.ready && !out_ch.last
        |=> corner_reg == $past(corner_reg) + 2'd1)
        else $error("corner index did not advance");

    a_units_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROT && state_next == ST_MAC |-> dx_done && dy_done && cor_done)
        else $error("corner math started before divide or rotation finished");
`endif

endmodule
`default_nettype wire

// ===== verif/odometry_corner_warp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odometry_corner_warp_checker
// Watches the sample and corner channels, predicts the four warped corners of
// every accepted sample and compares each corner beat in order.
// ----------------------------------------------------------------------------
module odometry_corner_warp_checker
    import owc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    owc_in_if                          in_ch,
    owc_out_if                         out_ch,
    output int                         errors,
    output int                         pending
);

    localparam int FB = 16;

    typedef struct packed {
        logic [1:0]         idx;
        logic signed [20:0] u;
        logic signed [20:0] v;
        logic               sat;
        logic               lst;
    } corner_t;

    corner_t corner_q[$];

    logic [3:0]  thr;
    logic [15:0] lag_f, um, vm;
    longint held, prev_x, prev_y, prev_h;
    logic [3:0]  miss;
    logic        prev_lvl;

    const longint atan_tab[24] = '{536870912, 316933406, 167458907, 85004756,
        42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

    assign pending = corner_q.size();

    function automatic void sin_cos(input longint mrad, output longint c, output longint s);
        logic [63:0] prod;
        logic [31:0] ph, dd;
        logic [1:0]  q;
        longint x, y, z, xs, ys;
        prod = 64'(mrad) * 64'd174992711;
        ph = prod[39:8];
        q = 2'((ph + 32'h2000_0000) >> 30);
        dd = ph - (32'(q) << 30);
        z = longint'($signed(dd));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= atan_tab[i];
            end else begin
                x += ys; y -= xs; z += atan_tab[i];
            end
        end
        case (q)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi,
                                    inout logic hit);
        if (v < lo) begin hit = 1; return lo; end
        if (v > hi) begin hit = 1; return hi; end
        return v;
    endfunction

    task automatic predict_corners(input longint ex, input longint ey, input longint raw,
                                   input logic lvl);
        longint xb, yb, h, lag, cb, sb, ca, sa, dx, dy, wx, wy, rx, ry;
        longint pu[2], pv[2];
        longint emax, omax;
        logic sat, junk;
        corner_t c;
        emax = (longint'(1) << (FB + 7)) - 1;
        omax = (longint'(1) << (FB + 4)) - 1;
        xb = -ey;
        if (xb > 8388607) xb = 8388607;
        yb = ex;
        if (raw != held) begin
            miss = miss + 4'd1;
            if (miss >= thr) begin
                miss = 0;
                held = raw;
            end
            h = held;
        end else begin
            miss = 0;
            h = raw;
        end
        lag = (prev_h * longint'(lag_f) + h * (65536 - longint'(lag_f))) / 65536;
        if (lvl != prev_lvl) begin
            prev_x = 0; prev_y = 0; prev_h = 0;
        end
        sin_cos(lag, cb, sb);
        sin_cos(prev_h, ca, sa);
        dx = ((xb - prev_x) * (longint'(1) << FB)) / 8100;
        dy = ((yb - prev_y) * (longint'(1) << FB)) / 10800;
        pu[0] = longint'(um);
        pu[1] = 65536 - longint'(um);
        pv[0] = longint'(vm);
        pv[1] = 65536 - longint'(vm);
        for (int k = 0; k < 4; k++) begin
            sat = 0;
            junk = 0;
            wx = clip(((cb * pu[k >> 1] - sb * pv[k & 1]) >>> 30) + dx, -emax, emax, junk);
            wy = clip(((sb * pu[k >> 1] + cb * pv[k & 1]) >>> 30) + dy, -emax, emax, junk);
            rx = clip((ca * wx + sa * wy) >>> 30, -omax - 1, omax, sat);
            ry = clip((ca * wy - sa * wx) >>> 30, -omax - 1, omax, sat);
            c.idx = 2'(k);
            c.u = 21'(rx);
            c.v = 21'(ry);
            c.sat = sat;
            c.lst = (k == 3);
            corner_q.push_back(c);
        end
        prev_x = xb; prev_y = yb; prev_h = lag; prev_lvl = lvl;
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        corner_t w;
        if (!rst_n) begin
            thr = DEBOUNCE_RESET; lag_f = LAG_RESET; um = 0; vm = 0;
            held = 0; miss = 0; prev_x = 0; prev_y = 0; prev_h = 0; prev_lvl = 0;
            errors = 0;
            corner_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index_t'(cfg_index))
                    CFG_DEBOUNCE: thr = cfg_data[3:0];
                    CFG_LAG:      lag_f = cfg_data;
                    CFG_UMARGIN:  um = cfg_data;
                    CFG_VMARGIN:  vm = cfg_data;
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                if (corner_q.size() == 0) begin
                    $display("%0t unexpected corner beat", $time);
                    errors++;
                end else begin
                    w = corner_q.pop_front();
                    if (out_ch.corner_index !== w.idx) report("corner_index", out_ch.corner_index, w.idx);
                    if (out_ch.u_coord !== w.u) report("u_coord", out_ch.u_coord, w.u);
                    if (out_ch.v_coord !== w.v) report("v_coord", out_ch.v_coord, w.v);
                    if (out_ch.saturated !== w.sat) report("saturated", out_ch.saturated, w.sat);
                    if (out_ch.last !== w.lst) report("last", out_ch.last, w.lst);
                end
            end
            if (in_ch.valid && in_ch.ready)
                predict_corners(longint'(in_ch.enc_x), longint'(in_ch.enc_y),
                                longint'(in_ch.enc_theta), in_ch.reset_flag);
        end
    end

endmodule

// ===== verif/odometry_corner_warp_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odometry_corner_warp_core_tb
// Drives odometry samples and register phases into the corner warp core,
// with bursty input and a stalling corner receiver, and gives the verdict.
// ----------------------------------------------------------------------------
module odometry_corner_warp_core_tb;
    import owc_pkg::*;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int errors, pending;
    bit long_hold;
    int burst_left;

    owc_in_if  #(.POS_W(24), .ANG_W(16)) in_ch ();
    owc_out_if #(.COORD_W(21))           out_ch ();

    odometry_corner_warp_core DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
    );

    odometry_corner_warp_checker CHK (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch),
        .errors(errors), .pending(pending)
    );

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("[odometry_corner_warp_core] ERROR");
        $finish;
    end

    // corner receiver: random stalls, quiet stretches, and one long hold-off
    initial begin
        int mode;
        out_ch.ready = 0;
        mode = 0;
        forever begin
            @(negedge clk);
            if (long_hold) out_ch.ready <= 0;
            else begin
                if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
                case (mode)
                    0: out_ch.ready <= 1;
                    1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: out_ch.ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    task automatic drain;
        in_ch.valid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    // valid stays up between beats of a burst; drain drops it at the end
    task automatic send_sample(input logic [23:0] x, input logic [23:0] y,
                               input logic [15:0] th, input logic lvl);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 150) : 0;
            if (gap > 0) begin
                in_ch.valid <= 0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        in_ch.valid <= 1;
        in_ch.enc_x <= x;
        in_ch.enc_y <= y;
        in_ch.enc_theta <= th;
        in_ch.reset_flag <= lvl;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic random_run(input int n);
        logic [15:0] th;
        logic lvl;
        lvl = 0;
        th = 0;
        for (int i = 0; i < n; i++) begin
            // heading mostly held, sometimes a short glitch or a step
            case ($urandom_range(0, 5))
                0: th = 16'($urandom);
                1: th = th + 16'($urandom_range(0, 200)) - 16'd100;
                default: ;
            endcase
            if ($urandom_range(0, 15) == 0) lvl = ~lvl;
            if ($urandom_range(0, 9) == 0)
                send_sample(24'($urandom), 24'($urandom), 16'($urandom),
                            1'($urandom_range(0, 1)));
            else
                send_sample(24'($signed(17'($urandom))), 24'($signed(17'($urandom))),
                            th, lvl);
        end
    endtask

    initial begin
        cfg_we = 0; cfg_index = CFG_DEBOUNCE; cfg_data = 0;
        in_ch.valid = 0; in_ch.enc_x = 0; in_ch.enc_y = 0;
        in_ch.enc_theta = 0; in_ch.reset_flag = 0;
        long_hold = 0;
        burst_left = 0;
        rst_n = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: field extremes, glitch filter, reset-level toggles
        send_sample(24'h000000, 24'h000000, 16'h0000, 0);
        send_sample(24'h7FFFFF, 24'h800000, 16'h7FFF, 0);
        send_sample(24'h800000, 24'h7FFFFF, 16'h8000, 1);
        send_sample(24'h800000, 24'h800000, 16'h8000, 1);
        send_sample(24'hFFFFFF, 24'h000001, 16'd1571, 0);
        send_sample(24'h000100, 24'h000200, 16'd1571, 0);
        send_sample(24'h000100, 24'h000200, 16'd1571, 0);
        send_sample(24'h000100, 24'h000200, 16'd100, 0);
        send_sample(24'h000100, 24'h000200, 16'd3142, 1);
        send_sample(24'h555555, 24'hAAAAAA, 16'h5555, 1);
        send_sample(24'hAAAAAA, 24'h555555, 16'hAAAA, 0);
        drain();

        write_reg(CFG_DEBOUNCE, 16'd0);
        write_reg(CFG_LAG, 16'd0);
        write_reg(CFG_UMARGIN, 16'd32768);
        write_reg(CFG_VMARGIN, 16'd65535);
        send_sample(24'h000000, 24'h000000, 16'd4712, 0);
        send_sample(24'h001000, 24'hFFF000, 16'hF000, 0);
        send_sample(24'h7FFFFF, 24'h7FFFFF, 16'h7FFF, 1);
        drain();

        write_reg(CFG_DEBOUNCE, 16'd15);
        write_reg(CFG_LAG, 16'd65535);
        write_reg(CFG_UMARGIN, 16'd6553);
        write_reg(CFG_VMARGIN, 16'd0);
        random_run(50);

        // long hold-off on the corner side while samples keep coming
        fork
            begin
                long_hold = 1;
                repeat (1500) @(negedge clk);
                long_hold = 0;
            end
            random_run(20);
        join
        drain();

        write_reg(CFG_DEBOUNCE, 16'd1);
        write_reg(CFG_LAG, 16'd32768);
        write_reg(CFG_UMARGIN, 16'd0);
        write_reg(CFG_VMARGIN, 16'd32768);
        random_run(60);
        drain();

        write_reg(CFG_DEBOUNCE, 16'(DEBOUNCE_RESET));
        write_reg(CFG_LAG, LAG_RESET);
        write_reg(CFG_UMARGIN, 16'($urandom_range(0, 32768)));
        write_reg(CFG_VMARGIN, 16'($urandom_range(0, 32768)));
        random_run(70);

        drain();
        if (errors == 0)
            $display("[odometry_corner_warp_core] OK");
        else
            $display("[odometry_corner_warp_core] ERROR");
        $finish;
    end

endmodule

// ===== odometry_corner_warp_core.f =====
rtl/owc_pkg.sv
rtl/owc_if.sv
rtl/owc_cdiv.sv
rtl/owc_cordic.sv
rtl/odometry_corner_warp_core.sv
verif/odometry_corner_warp_checker.sv
verif/odometry_corner_warp_core_tb.sv
